>>> design/adtc_pkg.sv
// shared types, constants and control structs for the accelerometer delta trigger
package adtc_pkg;

    localparam int NUM_AXES      = 3;
    localparam int SAMPLE_W      = 16;
    localparam int SUM_W         = 21;
    localparam int MAG30_W       = 20;
    localparam int CALIB_SAMPLES = 30;
    localparam int CALIB_CNT_W   = 5;
    localparam int BUF_DEPTH     = 64;
    localparam int BUF_AW        = 6;
    localparam int BUF_CNT_W     = 7;
    localparam int ENTRY_W       = NUM_AXES * SAMPLE_W;

    // floor(2^24 / 30), quotient may come out one low and is corrected
    localparam int          RECIP30_SHIFT = 24;
    localparam logic [19:0] RECIP30       = 20'd559240;
    // floor(2^20 / 3)
    localparam int          RECIP3_SHIFT  = 20;
    localparam logic [18:0] RECIP3        = 19'd349525;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_MUL,
        S_DIV_FIX,
        S_MRG_MUL,
        S_MRG_FIX,
        S_RESULT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic load_prev;
        logic accum;
        logic div_mul;
        logic div_fix;
    } t_lane_ctl;

    typedef struct packed {
        logic mul;
        logic fix;
    } t_mrg_ctl;

endpackage

>>> design/adtc_ram.sv
// generic single write port ram with registered read
module adtc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/adtc_lane.sv
// one axis lane: previous sample, delta compare, calibration sum and divide by 30
module adtc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adtc_pkg::t_lane_ctl i_ctl,
    input  adtc_pkg::t_sample   i_sample,
    input  adtc_pkg::t_sample   i_threshold,
    output logic                o_moved,
    output adtc_pkg::t_sample   o_quot
);
    import adtc_pkg::*;

    logic signed [SAMPLE_W-1:0]  r_prev;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SUM_W-1:0]     n_sum;
    logic signed [SUM_W-1:0]     w_neg_sum;
    logic [MAG30_W-1:0]          w_mag;
    logic [MAG30_W-1:0]          r_mag;
    logic                        r_neg;
    logic [2*MAG30_W-1:0]        r_prod;
    logic [SAMPLE_W-1:0]         w_q0;
    logic [MAG30_W:0]            w_q0_ext;
    logic [MAG30_W:0]            w_q0x30;
    logic [MAG30_W:0]            w_rem;
    logic [SAMPLE_W:0]           w_q;
    logic [SAMPLE_W:0]           w_sq;
    logic signed [SAMPLE_W-1:0]  r_quot;
    logic signed [SAMPLE_W:0]    w_delta;
    logic signed [SAMPLE_W:0]    w_thr;
    logic signed [SAMPLE_W:0]    w_nthr;

    // delta against previous sample, exact in 17 bits
    assign w_delta = {r_prev[SAMPLE_W-1], r_prev} - {i_sample[SAMPLE_W-1], i_sample};
    assign w_thr   = {i_threshold[SAMPLE_W-1], i_threshold};
    assign w_nthr  = -w_thr;
    assign o_moved = (w_delta > w_thr) || (w_delta < w_nthr);

    assign n_sum = r_sum + {{(SUM_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};

    // magnitude of the sum fits 20 bits
    assign w_neg_sum = -r_sum;
    assign w_mag = r_sum[SUM_W-1] ? w_neg_sum[MAG30_W-1:0] : r_sum[MAG30_W-1:0];

    // correction step of the reciprocal divide
    assign w_q0     = r_prod[RECIP30_SHIFT +: SAMPLE_W];
    assign w_q0_ext = {{(MAG30_W+1-SAMPLE_W){1'b0}}, w_q0};
    assign w_q0x30  = (w_q0_ext << 5) - (w_q0_ext << 1);
    assign w_rem    = {1'b0, r_mag} - w_q0x30;
    assign w_q      = {1'b0, w_q0}
                    + (SAMPLE_W+1)'(w_rem >= (MAG30_W+1)'(CALIB_SAMPLES));
    assign w_sq     = r_neg ? -w_q : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.accum) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prev) begin
            r_prev <= i_sample;
        end
        if (i_ctl.div_mul) begin
            r_prod <= w_mag * RECIP30;
            r_mag  <= w_mag;
            r_neg  <= r_sum[SUM_W-1];
        end
        if (i_ctl.div_fix) begin
            r_quot <= w_sq[SAMPLE_W-1:0];
        end
    end

    assign o_quot = r_quot;

endmodule

>>> design/adtc_merge.sv
// merges lane results: any-axis motion and threshold as mean of the axis means
module adtc_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  adtc_pkg::t_mrg_ctl              i_ctl,
    input  adtc_pkg::t_sample               i_quot [adtc_pkg::NUM_AXES],
    input  logic [adtc_pkg::NUM_AXES-1:0]   i_moved,
    output logic                            o_moved,
    output adtc_pkg::t_sample               o_threshold
);
    import adtc_pkg::*;

    localparam int TSUM_W = SAMPLE_W + 2;
    localparam int TMAG_W = SAMPLE_W + 1;
    localparam int RCP_W  = 19;

    logic signed [TSUM_W-1:0]    w_sum;
    logic signed [TSUM_W-1:0]    w_neg_sum;
    logic [TMAG_W-1:0]           w_mag;
    logic [TMAG_W-1:0]           r_mag;
    logic                        r_neg;
    logic [TMAG_W+RCP_W-1:0]     r_prod;
    logic [SAMPLE_W-1:0]         w_q0;
    logic [TSUM_W-1:0]           w_q0_ext;
    logic [TSUM_W-1:0]           w_q0x3;
    logic [TSUM_W-1:0]           w_rem;
    logic [SAMPLE_W:0]           w_q;
    logic [SAMPLE_W:0]           w_sq;
    logic signed [SAMPLE_W-1:0]  r_thr;

    assign o_moved = |i_moved;

    always_comb begin
        w_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_sum = w_sum + {{(TSUM_W-SAMPLE_W){i_quot[a][SAMPLE_W-1]}}, i_quot[a]};
        end
    end

    assign w_neg_sum = -w_sum;
    assign w_mag = w_sum[TSUM_W-1] ? w_neg_sum[TMAG_W-1:0] : w_sum[TMAG_W-1:0];

    assign w_q0     = r_prod[RECIP3_SHIFT +: SAMPLE_W];
    assign w_q0_ext = {{(TSUM_W-SAMPLE_W){1'b0}}, w_q0};
    assign w_q0x3   = (w_q0_ext << 1) + w_q0_ext;
    assign w_rem    = {1'b0, r_mag} - w_q0x3;
    assign w_q      = {1'b0, w_q0} + (SAMPLE_W+1)'(w_rem >= TSUM_W'(NUM_AXES));
    assign w_sq     = r_neg ? -w_q : w_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= w_mag * RECIP3;
            r_mag  <= w_mag;
            r_neg  <= w_sum[TSUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_ctl.fix) begin
            r_thr <= w_sq[SAMPLE_W-1:0];
        end
    end

    assign o_threshold = r_thr;

endmodule

>>> design/accel_delta_trigger_capture.sv
// top level: accelerometer delta trigger with pre/post trigger capture buffer
// an accepted input passes the exec state, then the result state, which waits for the output
// register to be free; the sample that closes calibration goes through the divide by 30 then
// by 3 (multiply, then correct, each) first, and a dump reads each entry from the ram, then loads
// it into the output register; a new input is accepted only in idle, once all results are loaded
// reset: sync active low, clears flags, counters, sums and threshold but not the buffer
module accel_delta_trigger_capture #(
    parameter int PRE_DEPTH  = 16,
    parameter int POST_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  adtc_pkg::t_sample i_accel_x,
    input  adtc_pkg::t_sample i_accel_y,
    input  adtc_pkg::t_sample i_accel_z,
    input  logic              i_clear_activity,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_triggered,
    output logic              o_activity,
    output logic              o_calibrating,
    output adtc_pkg::t_sample o_threshold_now,
    output logic              o_is_dump,
    output adtc_pkg::t_sample o_dump_x,
    output adtc_pkg::t_sample o_dump_y,
    output adtc_pkg::t_sample o_dump_z,
    output logic              o_last_in_run
);
    import adtc_pkg::*;

    localparam logic [BUF_CNT_W-1:0] PRE_LIM  = BUF_CNT_W'(PRE_DEPTH);
    localparam logic [BUF_CNT_W-1:0] POST_LIM = BUF_CNT_W'(POST_DEPTH);

    // control state
    t_state                  r_state, n_state;
    logic                    r_seeded, n_seeded;
    logic [CALIB_CNT_W-1:0]  r_calib_cnt, n_calib_cnt;
    logic                    r_activity, n_activity;
    logic                    r_armed, n_armed;
    logic [BUF_AW-1:0]       r_head, n_head;
    logic [BUF_CNT_W-1:0]    r_count, n_count;
    logic                    r_trig, n_trig;
    logic                    r_calib_flag, n_calib_flag;
    logic [BUF_CNT_W-1:0]    r_dump_cnt, n_dump_cnt;
    logic [BUF_AW-1:0]       r_dump_idx, n_dump_idx;
    logic                    r_out_valid, n_out_valid;

    // payload registers
    t_sample                 r_sample [NUM_AXES];
    logic                    r_clr;
    logic                    r_out_triggered;
    logic                    r_out_activity;
    logic                    r_out_calibrating;
    t_sample                 r_out_threshold;
    logic                    r_out_is_dump;
    t_sample                 r_out_dump [NUM_AXES];
    logic                    r_out_last;

    // lane and merge wiring
    t_lane_ctl               w_lane_ctl;
    t_mrg_ctl                w_mrg_ctl;
    logic [NUM_AXES-1:0]     w_moved;
    t_sample                 w_quot [NUM_AXES];
    logic                    w_any_moved;
    t_sample                 w_threshold;

    // history buffer wiring
    logic                    w_ram_we;
    logic [BUF_AW-1:0]       w_ram_waddr;
    logic [ENTRY_W-1:0]      w_ram_wdata;
    logic                    w_ram_re;
    logic [BUF_AW-1:0]       w_ram_raddr;
    logic [ENTRY_W-1:0]      w_ram_rdata;

    // combinational helpers
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_load_status;
    logic                    w_load_dump;
    logic                    w_dump_last;
    logic                    w_act_cleared;
    logic                    w_armed_new;
    logic [BUF_CNT_W-1:0]    w_limit;
    logic [BUF_CNT_W-1:0]    w_count_new;
    logic [BUF_AW-1:0]       w_head_new;

    assign o_in_ready    = (r_state == S_IDLE);
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_act_cleared = r_clr ? 1'b0 : r_activity;
    assign w_dump_last   = ({1'b0, r_dump_idx} == (r_dump_cnt - BUF_CNT_W'(1)));

    // one lane per axis
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        adtc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_lane_ctl),
            .i_sample    (r_sample[a]),
            .i_threshold (w_threshold),
            .o_moved     (w_moved[a]),
            .o_quot      (w_quot[a])
        );
    end

    adtc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mrg_ctl),
        .i_quot      (w_quot),
        .i_moved     (w_moved),
        .o_moved     (w_any_moved),
        .o_threshold (w_threshold)
    );

    // circular history of samples, x in the low bits
    assign w_ram_wdata = {r_sample[2], r_sample[1], r_sample[0]};

    adtc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUF_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // sequencer: next state and datapath controls
    always_comb begin
        n_state       = r_state;
        n_seeded      = r_seeded;
        n_calib_cnt   = r_calib_cnt;
        n_activity    = r_activity;
        n_armed       = r_armed;
        n_head        = r_head;
        n_count       = r_count;
        n_trig        = r_trig;
        n_calib_flag  = r_calib_flag;
        n_dump_cnt    = r_dump_cnt;
        n_dump_idx    = r_dump_idx;
        w_lane_ctl    = '0;
        w_mrg_ctl     = '0;
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_head + r_count[BUF_AW-1:0];
        w_ram_re      = 1'b0;
        w_ram_raddr   = r_head + r_dump_idx;
        w_load_status = 1'b0;
        w_load_dump   = 1'b0;
        w_armed_new   = r_armed;
        w_limit       = PRE_LIM;
        w_count_new   = r_count;
        w_head_new    = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // clear request is honored before anything else
                n_activity = w_act_cleared;
                if (!r_seeded) begin
                    // first sample only seeds the previous-sample registers
                    w_lane_ctl.load_prev = 1'b1;
                    n_seeded             = 1'b1;
                    n_calib_flag         = 1'b1;
                    n_trig               = 1'b0;
                    n_state              = S_RESULT;
                end else if (r_calib_cnt < CALIB_CNT_W'(CALIB_SAMPLES)) begin
                    w_lane_ctl.accum = 1'b1;
                    n_calib_cnt      = r_calib_cnt + CALIB_CNT_W'(1);
                    n_calib_flag     = 1'b1;
                    n_trig           = 1'b0;
                    if (r_calib_cnt == CALIB_CNT_W'(CALIB_SAMPLES - 1)) begin
                        n_state = S_DIV_MUL;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else begin
                    n_calib_flag = 1'b0;
                    n_trig       = 1'b0;
                    if (w_any_moved && !w_act_cleared) begin
                        n_activity  = 1'b1;
                        w_armed_new = 1'b1;
                        n_trig      = 1'b1;
                    end
                    w_lane_ctl.load_prev = 1'b1;
                    // push sample, dropping the oldest when full
                    w_ram_we = 1'b1;
                    w_limit  = w_armed_new ? POST_LIM : PRE_LIM;
                    if (r_count >= w_limit) begin
                        w_head_new = r_head + BUF_AW'(1);
                    end else begin
                        w_count_new = r_count + BUF_CNT_W'(1);
                    end
                    n_head = w_head_new;
                    if (w_armed_new && (w_count_new >= w_limit)) begin
                        // post-trigger window filled: dump and empty the buffer
                        n_dump_cnt = w_count_new;
                        n_dump_idx = '0;
                        n_count    = '0;
                        n_armed    = 1'b0;
                        n_state    = S_DUMP_RD;
                    end else begin
                        n_count = w_count_new;
                        n_armed = w_armed_new;
                        n_state = S_RESULT;
                    end
                end
            end
            S_DIV_MUL: begin
                w_lane_ctl.div_mul = 1'b1;
                n_state            = S_DIV_FIX;
            end
            S_DIV_FIX: begin
                w_lane_ctl.div_fix = 1'b1;
                n_state            = S_MRG_MUL;
            end
            S_MRG_MUL: begin
                w_mrg_ctl.mul = 1'b1;
                n_state       = S_MRG_FIX;
            end
            S_MRG_FIX: begin
                w_mrg_ctl.fix = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    w_load_status = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                w_ram_re = 1'b1;
                n_state  = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (w_out_free) begin
                    w_load_dump = 1'b1;
                    n_dump_idx  = r_dump_idx + BUF_AW'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register handshake
        if (w_load_status || w_load_dump) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seeded     <= 1'b0;
            r_calib_cnt  <= '0;
            r_activity   <= 1'b0;
            r_armed      <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_trig       <= 1'b0;
            r_calib_flag <= 1'b0;
            r_dump_cnt   <= '0;
            r_dump_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seeded     <= n_seeded;
            r_calib_cnt  <= n_calib_cnt;
            r_activity   <= n_activity;
            r_armed      <= n_armed;
            r_head       <= n_head;
            r_count      <= n_count;
            r_trig       <= n_trig;
            r_calib_flag <= n_calib_flag;
            r_dump_cnt   <= n_dump_cnt;
            r_dump_idx   <= n_dump_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample[0] <= i_accel_x;
            r_sample[1] <= i_accel_y;
            r_sample[2] <= i_accel_z;
            r_clr       <= i_clear_activity;
        end
    end

    // output payload, status fields shared by every result of one transaction
    always_ff @(posedge i_clk) begin
        if (w_load_status || w_load_dump) begin
            r_out_triggered   <= r_trig;
            r_out_activity    <= r_activity;
            r_out_calibrating <= r_calib_flag;
            r_out_threshold   <= r_calib_flag ? '0 : w_threshold;
        end
        if (w_load_status) begin
            r_out_is_dump <= 1'b0;
            r_out_last    <= 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_dump[a] <= '0;
            end
        end else if (w_load_dump) begin
            r_out_is_dump <= 1'b1;
            r_out_last    <= w_dump_last;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out_dump[a] <= w_ram_rdata[a*SAMPLE_W +: SAMPLE_W];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_triggered     = r_out_triggered;
    assign o_activity      = r_out_activity;
    assign o_calibrating   = r_out_calibrating;
    assign o_threshold_now = r_out_threshold;
    assign o_is_dump       = r_out_is_dump;
    assign o_dump_x        = r_out_dump[0];
    assign o_dump_y        = r_out_dump[1];
    assign o_dump_z        = r_out_dump[2];
    assign o_last_in_run   = r_out_last;

endmodule

>>> design/adtc_checker.sv
// port-level checker for the delta trigger block and its bind
module adtc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input adtc_pkg::t_sample i_accel_x,
    input adtc_pkg::t_sample i_accel_y,
    input adtc_pkg::t_sample i_accel_z,
    input logic              i_clear_activity,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_triggered,
    input logic              o_activity,
    input logic              o_calibrating,
    input adtc_pkg::t_sample o_threshold_now,
    input logic              o_is_dump,
    input adtc_pkg::t_sample o_dump_x,
    input adtc_pkg::t_sample o_dump_y,
    input adtc_pkg::t_sample o_dump_z,
    input logic              o_last_in_run
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a status-only result is the single, last result and carries no samples
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_dump |-> o_last_in_run && (o_dump_x == '0)
            && (o_dump_y == '0) && (o_dump_z == '0))
        else $error("status result with sample data or not last");

    // calibration results never trigger, dump, or show a threshold
    a_calib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_calibrating |-> (o_threshold_now == '0) && !o_triggered
            && !o_is_dump)
        else $error("calibration result with run-time fields");

    // a trigger always leaves activity set
    a_trig_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_triggered |-> o_activity)
        else $error("trigger without activity");

endmodule

bind accel_delta_trigger_capture adtc_checker u_adtc_checker (.*);
